### rtl/ssbo_pkg.sv
// Shared types, widths and codes for the swept-sphere box overlap block.
// Used by every module under rtl; depends on nothing else.
package ssbo_pkg;

	// Coordinate and fraction formats.
	localparam int CW    = 32;          // Q16.16 coordinate width
	localparam int FB    = 16;          // fraction bits, 2^FB means 1.0
	localparam int FW    = FB + 1;      // fraction field width
	localparam int DW    = CW + 1;      // segment delta per axis
	localparam int QW    = CW + 2;      // min + max - 2 * start per axis
	localparam int PW    = QW + DW;     // one product of the dot product
	localparam int SW    = PW + 2;      // signed dot product
	localparam int LW    = 2 * CW + 2;  // squared segment length
	localparam int DENW  = LW + 1;      // divisor, twice the squared length
	localparam int RW    = DENW + 1;    // divider remainder after shift
	localparam int ROOTW = LW / 2;      // integer root of the squared length
	localparam int PRW   = DW + FW + 1; // delta times fraction
	localparam int LOCW  = CW + 3;      // location on the segment
	localparam int EW    = CW + 4;      // signed excess per axis
	localparam int SQW   = 2 * (EW - 1);
	localparam int XW    = SQW + 2;     // sum of squared excesses
	localparam int RADW  = CW - 1;
	localparam int R2W   = 2 * RADW;
	localparam int DPW   = ROOTW + FW;  // root times fraction
	localparam int DLW   = DPW - FB;
	localparam int IDXW  = 3;
	localparam int INW   = 6 * CW;
	localparam int OUTRAW = 1 + FW + 7 * CW;
	localparam int OUTW  = ((OUTRAW + 7) / 8) * 8;
	localparam int QDEPTH = 4;
	localparam int QAW   = 2;

	localparam logic [FW-1:0] FRAC_ONE = FW'(1) << FB;

	// Register indexes of the configuration port.
	localparam logic [IDXW-1:0] REG_START_X = 3'd0;
	localparam logic [IDXW-1:0] REG_START_Y = 3'd1;
	localparam logic [IDXW-1:0] REG_START_Z = 3'd2;
	localparam logic [IDXW-1:0] REG_END_X   = 3'd3;
	localparam logic [IDXW-1:0] REG_END_Y   = 3'd4;
	localparam logic [IDXW-1:0] REG_END_Z   = 3'd5;
	localparam logic [IDXW-1:0] REG_RADIUS  = 3'd6;

	// How the fraction of one box is settled.
	typedef enum logic [1:0] {
		MODE_ZERO,
		MODE_ONE,
		MODE_DIV
	} ssbo_mode_t;

	// Trace setup sequencer.
	typedef enum logic [1:0] {
		ST_SETTLE,
		ST_ROOT,
		ST_IDLE
	} ssbo_state_t;

	// Box corners: min x, y, z then max x, y, z, lowest element first.
	typedef logic [5:0][CW-1:0] ssbo_box_t;

	// Values derived from the trace registers.
	typedef struct packed {
		logic [2:0][CW-1:0] s;
		logic [2:0][DW-1:0] d;
		logic [DENW-1:0]    den;
		logic               nz;
		logic [ROOTW-1:0]   root;
		logic [R2W-1:0]     r2;
	} ssbo_trace_t;

	// One classified box between the front and back parts.
	typedef struct packed {
		ssbo_mode_t      mode;
		logic [DENW-1:0] dot;
		ssbo_box_t       box;
	} ssbo_item_t;

endpackage

### rtl/ssbo_setup.sv
// Trace registers, derived segment values and a bit-serial square root.
// Depends on ssbo_pkg.
module ssbo_setup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [ssbo_pkg::IDXW-1:0]     cfg_index,
	input  logic [ssbo_pkg::CW-1:0]       cfg_data,
	output ssbo_pkg::ssbo_trace_t         trace,
	output logic                          busy
);

	logic [2:0][ssbo_pkg::CW-1:0]   start_q, end_q;
	logic [ssbo_pkg::RADW-1:0]      radius_q;
	logic [2:0][ssbo_pkg::DW-1:0]   d_q;
	logic [2:0][2*ssbo_pkg::DW-1:0] sq_q;
	logic [ssbo_pkg::LW-1:0]        len2_q;
	logic [ssbo_pkg::R2W-1:0]       r2_q;

	ssbo_pkg::ssbo_state_t state_q, state_d;
	logic [1:0]              cnt_q, cnt_d;
	logic [ssbo_pkg::LW-1:0] num_q, num_d, res_q, res_d, rbit_q, rbit_d, trial;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q  <= '0;
			end_q    <= '0;
			radius_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				ssbo_pkg::REG_START_X: start_q[0] <= cfg_data;
				ssbo_pkg::REG_START_Y: start_q[1] <= cfg_data;
				ssbo_pkg::REG_START_Z: start_q[2] <= cfg_data;
				ssbo_pkg::REG_END_X:   end_q[0]   <= cfg_data;
				ssbo_pkg::REG_END_Y:   end_q[1]   <= cfg_data;
				ssbo_pkg::REG_END_Z:   end_q[2]   <= cfg_data;
				ssbo_pkg::REG_RADIUS:  radius_q   <= cfg_data[ssbo_pkg::RADW-1:0];
				default: ;
			endcase
		end
	end

	// The squared length follows the registers through three register levels, the squared radius through one.
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			d_q[a]  <= ssbo_pkg::DW'($signed(end_q[a])) - ssbo_pkg::DW'($signed(start_q[a]));
			sq_q[a] <= $signed(d_q[a]) * $signed(d_q[a]);
		end
		len2_q <= ssbo_pkg::LW'(sq_q[0]) + ssbo_pkg::LW'(sq_q[1]) + ssbo_pkg::LW'(sq_q[2]);
		r2_q   <= radius_q * radius_q;
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssbo_pkg::ST_SETTLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		num_q  <= num_d;
		res_q  <= res_d;
		rbit_q <= rbit_d;
	end

	// Wait for the squared length, then take its root one bit pair a cycle.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		num_d   = num_q;
		res_d   = res_q;
		rbit_d  = rbit_q;
		trial   = res_q + rbit_q;
		case (state_q)
			ssbo_pkg::ST_SETTLE: begin
				cnt_d = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					state_d = ssbo_pkg::ST_ROOT;
					num_d   = len2_q;
					res_d   = '0;
					rbit_d  = ssbo_pkg::LW'(1) << (ssbo_pkg::LW - 2);
				end
			end
			ssbo_pkg::ST_ROOT: begin
				if (rbit_q == '0) begin
					state_d = ssbo_pkg::ST_IDLE;
				end else begin
					if (num_q >= trial) begin
						num_d = num_q - trial;
						res_d = (res_q >> 1) + rbit_q;
					end else begin
						res_d = res_q >> 1;
					end
					rbit_d = rbit_q >> 2;
				end
			end
			ssbo_pkg::ST_IDLE: ;
			default: state_d = ssbo_pkg::ST_SETTLE;
		endcase
		if (cfg_wen) begin
			state_d = ssbo_pkg::ST_SETTLE;
			cnt_d   = '0;
		end
	end

	assign busy       = (state_q != ssbo_pkg::ST_IDLE);
	assign trace.s    = start_q;
	assign trace.d    = d_q;
	assign trace.den  = {len2_q, 1'b0};
	assign trace.nz   = |len2_q;
	assign trace.root = res_q[ssbo_pkg::ROOTW-1:0];
	assign trace.r2   = r2_q;

	// A write always restarts the setup.
	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen |=> busy) else $error("setup not restarted by a write");

endmodule

### rtl/ssbo_front.sv
// Front part: accepts boxes, forms the dot product and classifies the fraction.
// Depends on ssbo_pkg.
module ssbo_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ssbo_pkg::ssbo_trace_t      trace,
	input  logic                       busy,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [ssbo_pkg::INW-1:0]   s_tdata,
	input  logic                       full,
	output logic                       push,
	output ssbo_pkg::ssbo_item_t       item
);

	logic en, acc;
	logic v_s1, v_s2, v_s3;
	ssbo_pkg::ssbo_box_t box_s1, box_s2, box_s3;
	logic signed [ssbo_pkg::QW-1:0] q_s2 [3];
	logic signed [ssbo_pkg::PW-1:0] p_s3 [3];
	logic [ssbo_pkg::SW-1:0] dot_c;
	logic pos_c, ge_c;

	assign en       = !v_s3 || !full;
	assign s_tready = en && !busy;
	assign acc      = s_tvalid && s_tready;

	// Valid bits of the three front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Centre offset per axis, then its product with the delta.
	always_ff @(posedge clk) begin
		if (en) begin
			box_s1 <= s_tdata;
			box_s2 <= box_s1;
			box_s3 <= box_s2;
			for (int a = 0; a < 3; a++) begin
				q_s2[a] <= ssbo_pkg::QW'($signed(box_s1[a])) + ssbo_pkg::QW'($signed(box_s1[a+3]))
					- (ssbo_pkg::QW'($signed(trace.s[a])) <<< 1);
				p_s3[a] <= q_s2[a] * $signed(trace.d[a]);
			end
		end
	end

	// Sum and classify: behind the start or a zero-length trace, beyond the end, or a real division.
	assign dot_c = ssbo_pkg::SW'(p_s3[0]) + ssbo_pkg::SW'(p_s3[1]) + ssbo_pkg::SW'(p_s3[2]);
	assign pos_c = !dot_c[ssbo_pkg::SW-1] && (dot_c != '0);
	assign ge_c  = dot_c >= ssbo_pkg::SW'(trace.den);

	always_comb begin
		item.box = box_s3;
		item.dot = dot_c[ssbo_pkg::DENW-1:0];
		if (!trace.nz || !pos_c) begin
			item.mode = ssbo_pkg::MODE_ZERO;
		end else if (ge_c) begin
			item.mode = ssbo_pkg::MODE_ONE;
		end else begin
			item.mode = ssbo_pkg::MODE_DIV;
		end
	end

	assign push = v_s3 && !full;

endmodule

### rtl/ssbo_queue.sv
// Four-entry queue that decouples the front and back parts.
// Depends on ssbo_pkg.
module ssbo_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ssbo_pkg::ssbo_item_t  wr_item,
	output logic                  full,
	input  logic                  pop,
	output ssbo_pkg::ssbo_item_t  rd_item,
	output logic                  empty
);

	ssbo_pkg::ssbo_item_t mem_q [ssbo_pkg::QDEPTH];
	logic [ssbo_pkg::QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [ssbo_pkg::QAW:0]   cnt_q;

	assign full    = (cnt_q == (ssbo_pkg::QAW+1)'(ssbo_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (ssbo_pkg::QAW+1)'(ssbo_pkg::QDEPTH)) else $error("queue count overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("pop from empty queue");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count not advanced");

endmodule

### rtl/ssbo_back.sv
// Back part: pipelined fraction divider, location, excess test and result register.
// Depends on ssbo_pkg.
module ssbo_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ssbo_pkg::ssbo_trace_t     trace,
	input  ssbo_pkg::ssbo_item_t      item,
	input  logic                      empty,
	output logic                      pop,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [ssbo_pkg::OUTW-1:0] m_tdata
);

	logic en;
	logic [ssbo_pkg::FB:0]    dv_q;
	logic [ssbo_pkg::RW-1:0]  rem_q  [ssbo_pkg::FB+1];
	logic [ssbo_pkg::FB-1:0]  quo_q  [ssbo_pkg::FB+1];
	ssbo_pkg::ssbo_mode_t     mode_q [ssbo_pkg::FB+1];
	ssbo_pkg::ssbo_box_t      box_q  [ssbo_pkg::FB+1];
	logic [ssbo_pkg::FW-1:0]  f_c;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [ssbo_pkg::FW-1:0]  f_s1, f_s2, f_s3, f_s4;
	ssbo_pkg::ssbo_box_t      box_s1, box_s2;
	logic signed [ssbo_pkg::PRW-1:0]  prod_s1 [3];
	logic signed [ssbo_pkg::LOCW-1:0] loc_s2  [3];
	logic [ssbo_pkg::DPW-1:0]         dprod_s2;
	logic [ssbo_pkg::EW-2:0]          e_s3 [3];
	logic [2:0][ssbo_pkg::CW-1:0]     loc_s3, loc_s4, imp_s3, imp_s4;
	logic [ssbo_pkg::CW-1:0]          dist_s3, dist_s4;
	logic [ssbo_pkg::SQW-1:0]         sq_s4 [3];
	logic [ssbo_pkg::OUTW-1:0]        m_tdata_s5;

	logic signed [ssbo_pkg::EW-1:0]   lo_c [3], hi_c [3], e_c [3];
	logic signed [ssbo_pkg::LOCW-1:0] mn_c [3], mx_c [3], cl_c [3], imp_c [3];
	logic [ssbo_pkg::DLW-1:0]         dl_c;
	logic [ssbo_pkg::XW-1:0]          ex_c;
	logic                             hit_c;

	assign en  = !v_s5 || m_tready;
	assign pop = en && !empty;

	// Valid bits of the whole back pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			dv_q <= {dv_q[ssbo_pkg::FB-1:0], !empty};
			v_s1 <= dv_q[ssbo_pkg::FB];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Divider input stage takes the queue head.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= ssbo_pkg::RW'(item.dot);
			quo_q[0]  <= '0;
			mode_q[0] <= item.mode;
			box_q[0]  <= item.box;
		end
	end

	// One restoring division step per stage, quotient bits from the top.
	for (genvar i = 0; i < ssbo_pkg::FB; i++) begin : g_div
		logic [ssbo_pkg::RW-1:0] sh;
		logic ge;
		assign sh = rem_q[i] << 1;
		assign ge = sh >= ssbo_pkg::RW'(trace.den);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i+1]  <= ge ? (sh - ssbo_pkg::RW'(trace.den)) : sh;
				quo_q[i+1]  <= {quo_q[i][ssbo_pkg::FB-2:0], ge};
				mode_q[i+1] <= mode_q[i];
				box_q[i+1]  <= box_q[i];
			end
		end
	end

	// Final fraction from the classification.
	always_comb begin
		case (mode_q[ssbo_pkg::FB])
			ssbo_pkg::MODE_ONE: f_c = ssbo_pkg::FRAC_ONE;
			ssbo_pkg::MODE_DIV: f_c = {1'b0, quo_q[ssbo_pkg::FB]};
			default:            f_c = '0;
		endcase
	end

	// Excess and clamp per axis from the registered location.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			mn_c[a] = ssbo_pkg::LOCW'($signed(box_s2[a]));
			mx_c[a] = ssbo_pkg::LOCW'($signed(box_s2[a+3]));
			lo_c[a] = ssbo_pkg::EW'(mn_c[a]) - ssbo_pkg::EW'(loc_s2[a]);
			hi_c[a] = ssbo_pkg::EW'(loc_s2[a]) - ssbo_pkg::EW'(mx_c[a]);
			e_c[a]  = (lo_c[a] > hi_c[a]) ? lo_c[a] : hi_c[a];
			if (e_c[a] < 0) e_c[a] = '0;
			cl_c[a]  = (loc_s2[a] < mx_c[a]) ? loc_s2[a] : mx_c[a];
			imp_c[a] = (cl_c[a] > mn_c[a]) ? cl_c[a] : mn_c[a];
		end
	end

	assign dl_c  = ssbo_pkg::DLW'(dprod_s2 >> ssbo_pkg::FB);
	assign ex_c  = ssbo_pkg::XW'(sq_s4[0]) + ssbo_pkg::XW'(sq_s4[1]) + ssbo_pkg::XW'(sq_s4[2]);
	assign hit_c = ex_c <= ssbo_pkg::XW'(trace.r2);

	// Location, distance, excess squares and the result register.
	always_ff @(posedge clk) begin
		if (en) begin
			f_s1   <= f_c;
			box_s1 <= box_q[ssbo_pkg::FB];
			for (int a = 0; a < 3; a++) begin
				prod_s1[a] <= $signed(trace.d[a]) * $signed({1'b0, f_c});
				loc_s2[a]  <= ssbo_pkg::LOCW'(prod_s1[a] >>> ssbo_pkg::FB)
					+ ssbo_pkg::LOCW'($signed(trace.s[a]));
				e_s3[a]    <= e_c[a][ssbo_pkg::EW-2:0];
				loc_s3[a]  <= loc_s2[a][ssbo_pkg::CW-1:0];
				imp_s3[a]  <= imp_c[a][ssbo_pkg::CW-1:0];
				sq_s4[a]   <= e_s3[a] * e_s3[a];
			end
			f_s2     <= f_s1;
			box_s2   <= box_s1;
			dprod_s2 <= trace.root * f_s1;
			f_s3     <= f_s2;
			dist_s3  <= (|dl_c[ssbo_pkg::DLW-1:ssbo_pkg::CW]) ? '1 : dl_c[ssbo_pkg::CW-1:0];
			f_s4     <= f_s3;
			loc_s4   <= loc_s3;
			imp_s4   <= imp_s3;
			dist_s4  <= dist_s3;
			m_tdata_s5 <= hit_c ? ssbo_pkg::OUTW'({imp_s4, loc_s4, dist_s4, f_s4, 1'b1}) : '0;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = m_tdata_s5;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata == '0)) else $error("miss with nonzero fields");
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[ssbo_pkg::FW:1] <= ssbo_pkg::FRAC_ONE)) else $error("fraction above one");

endmodule

### rtl/swept_sphere_box_overlap.sv
// Swept-sphere versus box test: one box per cycle against a configured trace.
// The rate holds only while the setup is idle and the receiver does not stall m_tready.
// The depth comes from the 16-stage fraction divider plus front and result stages.
// After reset and after every configuration write, s_tready stays low
// while the squared length settles and its root is taken one bit a cycle.
module swept_sphere_box_overlap (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [ssbo_pkg::IDXW-1:0]  cfg_index,
	input  logic [ssbo_pkg::CW-1:0]    cfg_data,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
	input  logic [ssbo_pkg::INW-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// hit, enter_fraction, hit_distance, location_x/y/z, impact_x/y/z, zero fill
	output logic [ssbo_pkg::OUTW-1:0]  m_tdata
);

	ssbo_pkg::ssbo_trace_t trace;
	ssbo_pkg::ssbo_item_t  wr_item, rd_item;
	logic busy, push, full, pop, empty;

	// Trace registers and derived values.
	ssbo_setup u_setup (
		.clk(clk), .arst_n(arst_n), .cfg_wen(cfg_wen), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .trace(trace), .busy(busy)
	);

	// Accept and classify.
	ssbo_front u_front (
		.clk(clk), .arst_n(arst_n), .trace(trace), .busy(busy), .s_tvalid(s_tvalid),
		.s_tready(s_tready), .s_tdata(s_tdata), .full(full), .push(push), .item(wr_item)
	);

	// Decoupling queue.
	ssbo_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wr_item(wr_item), .full(full),
		.pop(pop), .rd_item(rd_item), .empty(empty)
	);

	// Divide, locate and test.
	ssbo_back u_back (
		.clk(clk), .arst_n(arst_n), .trace(trace), .item(rd_item), .empty(empty),
		.pop(pop), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

endmodule

### test/tb.sv
// Self-checking testbench for swept_sphere_box_overlap: streams boxes against
// configured traces and compares every result with a built-in predictor.
// Depends on rtl/ssbo_pkg.sv and rtl/swept_sphere_box_overlap.sv.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW     = ssbo_pkg::CW;
	localparam int FB     = ssbo_pkg::FB;
	localparam int FW     = ssbo_pkg::FW;
	localparam int IDXW   = ssbo_pkg::IDXW;
	localparam int INW    = ssbo_pkg::INW;
	localparam int RADW   = ssbo_pkg::RADW;
	localparam int OUTW   = ssbo_pkg::OUTW;
	localparam int OUTRAW = ssbo_pkg::OUTRAW;
	localparam logic [IDXW-1:0] REG_START_X = ssbo_pkg::REG_START_X;
	localparam logic [IDXW-1:0] REG_START_Y = ssbo_pkg::REG_START_Y;
	localparam logic [IDXW-1:0] REG_START_Z = ssbo_pkg::REG_START_Z;
	localparam logic [IDXW-1:0] REG_END_X   = ssbo_pkg::REG_END_X;
	localparam logic [IDXW-1:0] REG_END_Y   = ssbo_pkg::REG_END_Y;
	localparam logic [IDXW-1:0] REG_END_Z   = ssbo_pkg::REG_END_Z;
	localparam logic [IDXW-1:0] REG_RADIUS  = ssbo_pkg::REG_RADIUS;

	typedef ssbo_pkg::ssbo_box_t ssbo_box_t;

	// One result as it appears on m_tdata, lowest field last.
	typedef struct packed {
		logic [OUTW-OUTRAW-1:0] fill;
		logic [CW-1:0]          impact_z;
		logic [CW-1:0]          impact_y;
		logic [CW-1:0]          impact_x;
		logic [CW-1:0]          location_z;
		logic [CW-1:0]          location_y;
		logic [CW-1:0]          location_x;
		logic [CW-1:0]          hit_distance;
		logic [FW-1:0]          enter_fraction;
		logic                   hit;
	} overlap_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_wen = 1'b0;
	logic [IDXW-1:0]  cfg_index = '0;
	logic [CW-1:0]    cfg_data = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [INW-1:0]   s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUTW-1:0]  m_tdata;

	// Trace registers as the predictor sees them.
	logic signed [CW-1:0] trace_start [3];
	logic signed [CW-1:0] trace_end [3];
	logic [RADW-1:0]      sweep_radius;

	overlap_t expected_overlaps [$];
	int       mismatches = 0;
	int       send_idle_pct = 0;
	int       recv_idle_pct = 0;
	int       quiet_cycles = 0;
	localparam int QUIET_LIMIT = 5000;

	swept_sphere_box_overlap dut (.*);

	always #5 clk = ~clk;

	// Predict the result for one box from the current trace.
	function automatic overlap_t predict_overlap(ssbo_box_t b);
		logic signed [127:0] s [3], d [3], mn [3], mx [3], loc [3];
		logic signed [127:0] len2, dot, den, ex, e, f, root, c, dl, v;
		overlap_t o;
		o = '0;
		len2 = 0;
		dot = 0;
		ex = 0;
		f = 0;
		for (int a = 0; a < 3; a++) begin
			s[a] = trace_start[a];
			d[a] = 128'(trace_end[a]) - s[a];
			mn[a] = $signed(b[a]);
			mx[a] = $signed(b[a+3]);
			len2 += d[a] * d[a];
			dot += (mn[a] + mx[a] - 2 * s[a]) * d[a];
		end
		if (len2 > 0 && dot > 0) begin
			den = 2 * len2;
			if (dot >= den)
				f = 128'sd1 << FB;
			else
				f = (dot << FB) / den;
		end
		for (int a = 0; a < 3; a++) begin
			loc[a] = s[a] + ((d[a] * f) >>> FB);
			e = mn[a] - loc[a];
			if (loc[a] - mx[a] > e)
				e = loc[a] - mx[a];
			if (e < 0)
				e = 0;
			ex += e * e;
		end
		if (ex > 128'(sweep_radius) * 128'(sweep_radius))
			return o;
		root = 0;
		for (int bt = 40; bt >= 0; bt--) begin
			c = root | (128'sd1 << bt);
			if (c * c <= len2)
				root = c;
		end
		dl = (root * f) >>> FB;
		o.hit = 1'b1;
		o.enter_fraction = f[FW-1:0];
		o.hit_distance = (dl > 128'sh0FFFF_FFFF) ? 32'hFFFF_FFFF : dl[31:0];
		o.location_x = loc[0][31:0];
		o.location_y = loc[1][31:0];
		o.location_z = loc[2][31:0];
		v = (loc[0] < mx[0]) ? loc[0] : mx[0];
		v = (v > mn[0]) ? v : mn[0];
		o.impact_x = v[31:0];
		v = (loc[1] < mx[1]) ? loc[1] : mx[1];
		v = (v > mn[1]) ? v : mn[1];
		o.impact_y = v[31:0];
		v = (loc[2] < mx[2]) ? loc[2] : mx[2];
		v = (v > mn[2]) ? v : mn[2];
		o.impact_z = v[31:0];
		return o;
	endfunction

	task automatic report(string field, logic [CW-1:0] got, logic [CW-1:0] want);
		$display("mismatch %s: got %h expected %h", field, got, want);
		mismatches++;
	endtask

	// Receiver stalls, result checking and the watchdog.
	always @(posedge clk) begin
		overlap_t got, want;
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && m_tvalid && m_tready) begin
			got = overlap_t'(m_tdata);
			if (expected_overlaps.size() == 0) begin
				report("unexpected result", got.hit_distance, '0);
			end else begin
				want = expected_overlaps.pop_front();
				if (got.hit != want.hit) report("hit", got.hit, want.hit);
				if (got.enter_fraction != want.enter_fraction)
					report("enter_fraction", got.enter_fraction, want.enter_fraction);
				if (got.hit_distance != want.hit_distance)
					report("hit_distance", got.hit_distance, want.hit_distance);
				if (got.location_x != want.location_x)
					report("location_x", got.location_x, want.location_x);
				if (got.location_y != want.location_y)
					report("location_y", got.location_y, want.location_y);
				if (got.location_z != want.location_z)
					report("location_z", got.location_z, want.location_z);
				if (got.impact_x != want.impact_x)
					report("impact_x", got.impact_x, want.impact_x);
				if (got.impact_y != want.impact_y)
					report("impact_y", got.impact_y, want.impact_y);
				if (got.impact_z != want.impact_z)
					report("impact_z", got.impact_z, want.impact_z);
			end
		end
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Offer one box, idling first at random; valid stays high for back-to-back boxes.
	task automatic send_box(ssbo_box_t b);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_overlaps.push_back(predict_overlap(b));
	endtask

	// Pause the sender until every expected result has come, plus the pipeline depth.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_overlaps.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDXW-1:0] idx, logic [CW-1:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx <= REG_END_Z && idx >= REG_END_X) trace_end[idx - REG_END_X] = val;
		else if (idx <= REG_START_Z) trace_start[idx] = val;
		else if (idx == REG_RADIUS) sweep_radius = val[RADW-1:0];
	endtask

	task automatic set_trace(logic [CW-1:0] sx, sy, sz, ex, ey, ez, rad);
		drain();
		write_reg(REG_START_X, sx);
		write_reg(REG_START_Y, sy);
		write_reg(REG_START_Z, sz);
		write_reg(REG_END_X, ex);
		write_reg(REG_END_Y, ey);
		write_reg(REG_END_Z, ez);
		write_reg(REG_RADIUS, rad);
		cfg_wen <= 1'b0;
	endtask

	function automatic ssbo_box_t make_box(logic [CW-1:0] x0, y0, z0, x1, y1, z1);
		return {z1, y1, x1, z0, y0, x0};
	endfunction

	function automatic logic [CW-1:0] sat32(longint v);
		if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
		if (v < -64'sh8000_0000) return 32'h8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255)
				: 32'h8000_0000 + $urandom_range(255);
			default: return sat32(longint'($signed($urandom())) >>> $urandom_range(8, 20));
		endcase
	endfunction

	// Mostly boxes placed around a point of the trace, some wild or inverted.
	function automatic ssbo_box_t rand_box();
		ssbo_box_t b;
		longint c, h, frac;
		int kind;
		kind = $urandom_range(9);
		frac = longint'($urandom_range(80000)) - 64'sd8000;
		for (int a = 0; a < 3; a++) begin
			if (kind < 7) begin
				c = longint'(trace_start[a]) +
					(((longint'(trace_end[a]) - trace_start[a]) * frac) >>> 16) +
					(longint'($signed($urandom())) >>> $urandom_range(6, 24));
				h = longint'($urandom()) >> $urandom_range(4, 30);
				b[a] = sat32(c - h);
				b[a+3] = sat32(c + h);
				if (kind == 6 && a == $urandom_range(2)) begin
					b[a+3] = sat32(c - h - 1);
					b[a] = sat32(c + h);
				end
			end else begin
				b[a] = $urandom();
				b[a+3] = (kind == 9) ? $urandom() : rand_coord();
			end
		end
		return b;
	endfunction

	task automatic test_zero_length();
		set_trace(32'h0001_0000, 32'hFFFE_0000, 32'h0, 32'h0001_0000, 32'hFFFE_0000, 32'h0,
			31'h0002_0000);
		send_box(make_box(32'h0, 32'hFFFD_0000, 32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_0000,
			32'h0001_0000));
		send_box(make_box(32'h0005_0000, 32'h0, 32'h0, 32'h0006_0000, 32'h1_0000, 32'h1_0000));
		send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
	endtask

	task automatic test_directed();
		set_trace(32'h0, 32'h0, 32'h0, 32'h000A_0000, 32'h0005_0000, 32'hFFFD_0000,
			31'h0001_0000);
		// Box behind the start, beyond the end, midway, inverted, inverted at the extremes, and a flat box.
		send_box(make_box(32'hFFF0_0000, 32'hFFF8_0000, 32'h0, 32'hFFF1_0000, 32'hFFF9_0000,
			32'h1_0000));
		send_box(make_box(32'h0014_0000, 32'h000A_0000, 32'hFFF8_0000, 32'h0015_0000,
			32'h000B_0000, 32'hFFF9_0000));
		send_box(make_box(32'h0004_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h0006_0000,
			32'h0003_0000, 32'hFFFF_0000));
		send_box(make_box(32'h0006_0000, 32'h0003_0000, 32'hFFFF_0000, 32'h0004_0000,
			32'h0002_0000, 32'hFFFE_0000));
		send_box(make_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_box(make_box(32'h0009_8000, 32'h0, 32'h0, 32'h0009_8000, 32'h0, 32'h0));
		// Radius zero: only a box touching the trace is a hit.
		set_trace(32'h0, 32'h0, 32'h0, 32'h000A_0000, 32'h0, 32'h0, 31'h0);
		send_box(make_box(32'h0003_0000, 32'h0, 32'h0, 32'h0004_0000, 32'h0, 32'h0));
		send_box(make_box(32'h0003_0000, 32'h1, 32'h0, 32'h0004_0000, 32'h1, 32'h0));
		// Longest trace with the largest radius, so the distance saturates.
		set_trace(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_box(make_box(32'h7FFF_0000, 32'h7FFF_0000, 32'h7FFF_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_box(make_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_box(make_box(32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1));
		send_box(make_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0));
		// A write past the last register changes no trace register.
		drain();
		write_reg(3'd7, 32'hFFFF_FFFF);
		cfg_wen <= 1'b0;
		send_box(make_box(32'h0, 32'h0, 32'h0, 32'h1, 32'h1, 32'h1));
	endtask

	task automatic test_random(int count, int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0)
				set_trace(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
					rand_coord(), rand_coord(),
					$urandom_range(3) == 0 ? $urandom() : $urandom() >> $urandom_range(1, 24));
			send_box(rand_box());
		end
	endtask

	initial begin
		for (int a = 0; a < 3; a++) begin
			trace_start[a] = '0;
			trace_end[a] = '0;
		end
		sweep_radius = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_zero_length();
		test_directed();
		test_random(350, 32, 68);
		test_random(350, 68, 32);
		test_random(350, 0, 0);
		drain();
		if (mismatches == 0 && expected_overlaps.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
